@@ design/dual_quadrature_decoder_macros.svh @@
// Assertion macros for the dual quadrature decoder top module.
`ifndef DUAL_QUADRATURE_DECODER_MACROS_SVH
`define DUAL_QUADRATURE_DECODER_MACROS_SVH

// Checked property, switched off while reset is held
`define DQD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked property, also checked during reset
`define DQD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ design/dqd_pkg.sv @@
// Package for the dual quadrature decoder: widths, item codes and shared types.
`timescale 1ns / 1ps
`default_nettype none

package dqd_pkg;

    // Position counter width and result width
    localparam int COUNT_BITS = 16;
    localparam int OUT_BITS   = 16;

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef logic signed [COUNT_BITS-1:0] t_count;
    typedef logic signed [OUT_BITS-1:0]   t_out_count;

    // Per-channel control from the top level
    typedef struct packed {
        logic sample;   // new line levels present this cycle
        logic clear;    // count is being read out and cleared
        logic mirror;   // count in the mirror sense (right channel)
        logic a;
        logic b;
    } t_chan_ctrl;

    // Sign extend or truncate a count to the result width
    function automatic t_out_count count_to_output(t_count c);
        return OUT_BITS'(c);
    endfunction

endpackage

`default_nettype wire

@@ design/dqd_channel.sv @@
// One decoder channel: stored line levels, x4 edge decode and position counter.
`timescale 1ns / 1ps
`default_nettype none

module dqd_channel import dqd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_chan_ctrl i_ctrl,
    output t_count          o_count
);

    logic   r_prev_a, r_prev_b;
    t_count r_count;
    logic   a_rise, a_fall, b_rise, b_fall;
    logic   fwd_grp, rev_grp;
    logic   step_up, step_dn;
    t_count n_count;

    // Edge detect against the stored levels
    always_comb begin
        a_rise = !r_prev_a &&  i_ctrl.a;
        a_fall =  r_prev_a && !i_ctrl.a;
        b_rise = !r_prev_b &&  i_ctrl.b;
        b_fall =  r_prev_b && !i_ctrl.b;
        fwd_grp = (i_ctrl.b && a_rise) || (!i_ctrl.b && a_fall) ||
                  (i_ctrl.a && b_fall) || (!i_ctrl.a && b_rise);
        rev_grp = (i_ctrl.b && a_fall) || (!i_ctrl.b && a_rise) ||
                  (i_ctrl.a && b_rise) || (!i_ctrl.a && b_fall);
    end

    // First group tested wins; mirror swaps which group counts up
    always_comb begin
        if (i_ctrl.mirror) begin
            step_up = rev_grp;
            step_dn = !rev_grp && fwd_grp;
        end else begin
            step_up = fwd_grp;
            step_dn = !fwd_grp && rev_grp;
        end
    end

    // Counter next value, wraps in two's complement
    always_comb begin
        n_count = r_count;
        if (i_ctrl.clear) begin
            n_count = '0;
        end else if (i_ctrl.sample) begin
            if (step_up) begin
                n_count = r_count + t_count'(1);
            end else if (step_dn) begin
                n_count = r_count - t_count'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a <= 1'b0;
            r_prev_b <= 1'b0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_ctrl.sample) begin
                r_prev_a <= i_ctrl.a;
                r_prev_b <= i_ctrl.b;
            end
        end
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

@@ design/dual_quadrature_decoder.sv @@
// Dual quadrature decoder: x4 decode of a left and a right encoder with readout.
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item per accept. A
//   sample item (i_kind = 0) brings the A/B levels of both encoders; each
//   channel compares them with its stored levels and steps its signed count
//   by one on any edge, the right channel in the mirror sense. A read item
//   (i_kind = 1) selects a channel with i_pick_right, returns its count on
//   the output channel and clears it. Sample items give no result.
//   Output channel (o_out_valid / i_out_stall) carries o_count_value and
//   o_from_right; a result stays until accepted.
//   The accept edge loads the input register, and a read item moves on from
//   there into the result register once that register is free.
//   Throughput: one item per cycle. The input register holds a read item
//   only while the result register is full and stalled; samples always
//   pass, so stalling the output stops the input only on a read.
//   Reset (i_rst_n low, synchronous) clears both counts, the stored levels
//   and all valid flags; no clearing sweep is needed.
`timescale 1ns / 1ps
`default_nettype none

`include "dual_quadrature_decoder_macros.svh"

module dual_quadrature_decoder import dqd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_kind,
    input  wire logic       i_left_a,
    input  wire logic       i_left_b,
    input  wire logic       i_right_a,
    input  wire logic       i_right_b,
    input  wire logic       i_pick_right,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic signed [OUT_BITS-1:0] o_count_value,
    output logic            o_from_right
);

    // Input register
    logic       r_s1_valid;
    logic       r_s1_kind;
    logic       r_s1_la, r_s1_lb, r_s1_ra, r_s1_rb;
    logic       r_s1_pick;

    // Result register
    logic       r_out_valid;
    t_out_count r_out_count;
    logic       r_out_right;

    logic       out_free;
    logic       s1_adv;
    logic       s1_read;
    logic       in_accept;
    t_chan_ctrl left_ctrl, right_ctrl;
    t_count     left_count, right_count;

    // Flow control: a read may leave the input register only into a free result slot
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_read    = r_s1_valid && (r_s1_kind == KIND_READ);
    assign s1_adv     = r_s1_valid && (!s1_read || out_free);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_kind <= i_kind;
            r_s1_la   <= i_left_a;
            r_s1_lb   <= i_left_b;
            r_s1_ra   <= i_right_a;
            r_s1_rb   <= i_right_b;
            r_s1_pick <= i_pick_right;
        end
    end

    // Channel control
    always_comb begin
        left_ctrl.sample  = s1_adv && (r_s1_kind == KIND_SAMPLE);
        left_ctrl.clear   = s1_adv && s1_read && !r_s1_pick;
        left_ctrl.mirror  = 1'b0;
        left_ctrl.a       = r_s1_la;
        left_ctrl.b       = r_s1_lb;
        right_ctrl.sample = s1_adv && (r_s1_kind == KIND_SAMPLE);
        right_ctrl.clear  = s1_adv && s1_read && r_s1_pick;
        right_ctrl.mirror = 1'b1;
        right_ctrl.a      = r_s1_ra;
        right_ctrl.b      = r_s1_rb;
    end

    dqd_channel u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (left_ctrl),
        .o_count (left_count)
    );

    dqd_channel u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (right_ctrl),
        .o_count (right_count)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_adv && s1_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_adv && s1_read) begin
            r_out_count <= r_s1_pick ? count_to_output(right_count)
                                     : count_to_output(left_count);
            r_out_right <= r_s1_pick;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_count_value = r_out_count;
    assign o_from_right  = r_out_right;

    // Checks
    `DQD_ASSERT(a_read_gives_result, (s1_adv && s1_read) |=> r_out_valid, "read item lost")
    `DQD_ASSERT(a_left_cleared, left_ctrl.clear |=> (left_count == '0), "left count not cleared")
    `DQD_ASSERT(a_stall_needs_item, o_in_stall |-> (s1_read && r_out_valid), "spurious input stall")
    `DQD_ASSERT_ALWAYS(a_reset_empty, $past(!i_rst_n) |-> (!r_out_valid && !r_s1_valid), "valid after reset")

endmodule

`default_nettype wire

@@ tb/sv/tb_dual_quadrature_decoder.sv @@
// Self-checking testbench for the dual quadrature decoder: directed table, spin, random walks.
`timescale 1ns / 1ps

module tb_dual_quadrature_decoder;
    import dqd_pkg::*;

    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 5;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int HOLD_CYCLES      = 400;
    localparam int SETTLE_CYCLES    = 8;
    localparam int RANDOM_PER_PHASE = 170;
    localparam int READ_PCT         = 15;
    localparam int SPIN_STEPS       = 48;   // spin samples in one direction, both channels

    typedef struct packed {
        logic kind;
        logic left_a;
        logic left_b;
        logic right_a;
        logic right_b;
        logic pick_right;
    } t_item;

    typedef struct packed {
        t_out_count value;
        logic       from_right;
    } t_count_read;

    typedef struct {
        t_item       item;
        bit          typed;   // want holds a hand-worked count
        t_count_read want;
    } t_row;

    logic i_clk        = 1'b0;
    logic i_rst_n      = 1'b0;
    logic i_in_valid   = 1'b0;
    logic i_kind       = 1'b0;
    logic i_left_a     = 1'b0;
    logic i_left_b     = 1'b0;
    logic i_right_a    = 1'b0;
    logic i_right_b    = 1'b0;
    logic i_pick_right = 1'b0;
    logic i_out_stall  = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    logic o_from_right;
    logic signed [OUT_BITS-1:0] o_count_value;

    // Decoder state as the testbench tracks it
    logic [3:0]  seen_levels = '0;   // bit0 left A, bit1 left B, bit2 right A, bit3 right B
    t_count      left_count  = '0;
    t_count      right_count = '0;
    t_count_read pending_reads[$];

    int idle_pct    = 0;
    int stall_pct   = 0;
    bit hold_req    = 1'b0;
    int hold_left   = 0;
    int idle_cycles = 0;
    int errors      = 0;
    int items_in    = 0;
    int left_reads  = 0;
    int right_reads = 0;

    // Directed items: reads after reset, single steps, double changes, ignored fields
    t_row directed_rows [21] = '{
        '{'{KIND_READ,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{16'sd0, 1'b0}},
        '{'{KIND_READ,   1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, '{16'sd0, 1'b1}},
        '{'{KIND_SAMPLE, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{KIND_READ,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{16'sd1, 1'b0}},
        '{'{KIND_READ,   1'b0, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b1, '{-16'sd1, 1'b1}},
        '{'{KIND_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{KIND_SAMPLE, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{KIND_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{KIND_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{KIND_READ,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{KIND_READ,   1'b0, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{KIND_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{KIND_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{KIND_SAMPLE, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{KIND_SAMPLE, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
        '{'{KIND_SAMPLE, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{KIND_READ,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
        '{'{KIND_READ,   1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{KIND_SAMPLE, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        '{'{KIND_READ,   1'b1, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
        '{'{KIND_READ,   1'b0, 1'b1, 1'b0, 1'b1, 1'b1}, 1'b0, '0}
    };

    dual_quadrature_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_left_a      (i_left_a),
        .i_left_b      (i_left_b),
        .i_right_a     (i_right_a),
        .i_right_b     (i_right_b),
        .i_pick_right  (i_pick_right),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_count_value (o_count_value),
        .o_from_right  (o_from_right)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // {a, b} levels of one encoder, in the order that counts the left channel up
    function automatic logic [1:0] gray_levels(int idx);
        case (idx & 3)
            0: return 2'b00;
            1: return 2'b01;
            2: return 2'b11;
            default: return 2'b10;
        endcase
    endfunction

    // Step of one channel: +1, -1 or 0; the mirror sense tries the other group first
    function automatic int quad_step(logic pa, logic pb, logic a, logic b, logic mirror);
        logic a_rise, a_fall, b_rise, b_fall, fwd, rev;
        a_rise = !pa && a;
        a_fall = pa && !a;
        b_rise = !pb && b;
        b_fall = pb && !b;
        fwd = (b && a_rise) || (!b && a_fall) || (a && b_fall) || (!a && b_rise);
        rev = (b && a_fall) || (!b && a_rise) || (a && b_rise) || (!a && b_fall);
        if (mirror ? rev : fwd) return 1;
        if (mirror ? fwd : rev) return -1;
        return 0;
    endfunction

    // Advance the tracked decoder by one item; returns 1 when a count is read out
    function automatic bit track_item(input t_item it, output t_count_read rd);
        rd = '0;
        if (it.kind == KIND_SAMPLE) begin
            left_count  = left_count + t_count'(quad_step(seen_levels[0], seen_levels[1],
                                                          it.left_a, it.left_b, 1'b0));
            right_count = right_count + t_count'(quad_step(seen_levels[2], seen_levels[3],
                                                           it.right_a, it.right_b, 1'b1));
            seen_levels = {it.right_b, it.right_a, it.left_b, it.left_a};
            return 1'b0;
        end
        if (it.pick_right) begin
            rd.value      = t_out_count'(right_count);
            rd.from_right = 1'b1;
            right_count   = '0;
        end else begin
            rd.value      = t_out_count'(left_count);
            rd.from_right = 1'b0;
            left_count    = '0;
        end
        return 1'b1;
    endfunction

    // Next position of a random encoder walk: mostly single steps, some jumps
    function automatic int walk_step(int idx);
        int r;
        r = $urandom_range(99);
        if (r < 40) return (idx + 1) & 3;
        if (r < 70) return (idx + 3) & 3;
        if (r < 80) return idx;
        if (r < 90) return (idx + 2) & 3;
        return $urandom_range(3);
    endfunction

    function automatic t_item random_item(inout int lidx, inout int ridx);
        t_item      it;
        logic [1:0] lv, rv;
        it = 6'($urandom_range(63));   // ignored fields stay random
        if ($urandom_range(99) < READ_PCT) begin
            it.kind = KIND_READ;
            return it;
        end
        it.kind    = KIND_SAMPLE;
        lidx       = walk_step(lidx);
        ridx       = walk_step(ridx);
        lv         = gray_levels(lidx);
        rv         = gray_levels(ridx);
        it.left_a  = lv[1];
        it.left_b  = lv[0];
        it.right_a = rv[1];
        it.right_b = rv[0];
        return it;
    endfunction

    // Offer one item, with random idle cycles ahead of it, and wait for it to be taken
    task automatic offer(input t_item it, input bit typed, input t_count_read want);
        t_count_read rd;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= it.kind;
        i_left_a     <= it.left_a;
        i_left_b     <= it.left_b;
        i_right_a    <= it.right_a;
        i_right_b    <= it.right_b;
        i_pick_right <= it.pick_right;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        items_in++;
        if (track_item(it, rd)) pending_reads.push_back(typed ? want : rd);
    endtask

    // Stop sending until every count read so far has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reads.size() != 0) @(posedge i_clk);
    endtask

    // Result check and receiver stall pattern
    always @(posedge i_clk) begin
        t_count_read want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reads.size() == 0) begin
                errors++;
                $display("%0t: count %0d (from_right %0b) arrived with none expected",
                         $time, o_count_value, o_from_right);
            end else begin
                want = pending_reads.pop_front();
                if (o_count_value !== want.value) begin
                    errors++;
                    $display("%0t: count_value expected %0d, got %0d",
                             $time, want.value, o_count_value);
                end
                if (o_from_right !== want.from_right) begin
                    errors++;
                    $display("%0t: from_right expected %0b, got %0b",
                             $time, want.from_right, o_from_right);
                end
                if (o_from_right) right_reads++;
                else left_reads++;
            end
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: too long without any item moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item accepted for %0d cycles", $time, idle_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        t_item      it;
        logic [1:0] lv;
        int         lidx;
        int         ridx;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        drain();

        // Spin in one direction: left counts up, right counts down
        for (int k = 0; k < SPIN_STEPS; k++) begin
            lv = gray_levels(k);
            it = '{KIND_SAMPLE, lv[1], lv[0], lv[1], lv[0], k[0]};
            offer(it, 1'b0, '0);
        end
        offer('{KIND_READ, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0);
        offer('{KIND_READ, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0);
        drain();

        // Random encoder walks under four idle/stall mixes
        lidx = (SPIN_STEPS - 1) & 3;
        ridx = lidx;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    hold_req  = 1'b1;   // long hold-off so reads back up into the input
                end
                1: begin
                    idle_pct  = 80;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 80;
                end
                default: begin
                    idle_pct  = 36;
                    stall_pct = 36;
                end
            endcase
            repeat (RANDOM_PER_PHASE) begin
                it = random_item(lidx, ridx);
                offer(it, 1'b0, '0);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Covered %0d items, %0d counts read back (%0d left, %0d right),",
                 items_in, left_reads + right_reads, left_reads, right_reads);
        $display("a %0d-step one-way spin and four idle/stall mixes; %0d mismatches.",
                 SPIN_STEPS, errors);
        if (errors == 0 && pending_reads.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/dqd_pkg.sv
design/dqd_channel.sv
design/dual_quadrature_decoder.sv
tb/sv/tb_dual_quadrature_decoder.sv
